FILE: hw/rtl/srtl_pkg.sv
// Package for the sorted region table lookup core.
// Table depth, derived widths, command codes and the structs shared by the cells.
// No dependencies.
package srtl_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned POS_W       = 7;   // fixed width of position / entries_held

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_LBOUND = 2'd3
  } cmd_e;

  // per-cycle load control for one cell
  typedef struct packed {
    logic load_new;   // take the inserted region
    logic shift_in;   // take the entry of the left neighbor
  } cell_ctl_t;

  // compare results of one cell against the current transfer
  typedef struct packed {
    logic lt_addr;    // base <  lookup address
    logic le_ins;     // base <= insert base
    logic eq_addr;    // base == lookup address
    logic holds;      // region contains lookup address
  } cell_flags_t;

endpackage

FILE: hw/rtl/sorted_region_table_lookup_core.sv
// Top level of the sorted region table lookup core.
// Instantiates the cell row and two boundary encoders. Depends on srtl_pkg.
//
// Usage:
//   The slave channel carries one command per transfer: tuser = cmd (clear,
//   insert, find, lower bound), tdata = region base, region length and lookup
//   address. The master channel returns exactly one result per command:
//   found, position, status (insert refused, table full) and entries held.
//   The table is a row of TABLE_DEPTH cells kept sorted by base. Every cell
//   compares its region with the command in parallel; the sorted row of
//   compare flags is turned into the lower bound (and the insert slot) by
//   locating its single 1-to-0 boundary. An insert shifts every cell at or
//   above the slot one place to the right, each cell taking its neighbor's
//   region, in the same cycle.
//   The result sits in an output register, valid in the cycle after the
//   input transfer. One command is taken every cycle unless the receiver
//   stalls (register full: s_axis_tready low, table held); the path is
//   the cell compare plus the boundary encode.
//   Reset empties the table (count to zero) at once; no clearing pass is
//   run, as entries beyond the count are never used.
module sorted_region_table_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] region_base, [63:32] region_length, [95:64] lookup_address
  input  logic [95:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] found, [7:1] position, [8] status, [15:9] entries_held
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned D = srtl_pkg::TABLE_DEPTH;
  localparam int unsigned W = srtl_pkg::ADDR_W;

  srtl_pkg::cmd_e cmd;
  logic [W-1:0]   rbase, rlen, addr;
  logic           accept;

  assign cmd   = srtl_pkg::cmd_e'(s_axis_tuser);
  assign rbase = s_axis_tdata[31:0];
  assign rlen  = s_axis_tdata[63:32];
  assign addr  = s_axis_tdata[95:64];

  // entry count
  logic [srtl_pkg::CNT_W-1:0] count_q, count_d;
  logic                       full;
  logic                       ins_ok;

  assign full   = count_q == srtl_pkg::CNT_W'(D);
  assign ins_ok = accept && (cmd == srtl_pkg::CMD_INSERT) && !full;

  // cell row
  logic [W-1:0]          cell_base [D];
  logic [W-1:0]          cell_len  [D];
  srtl_pkg::cell_flags_t cell_flags [D];
  srtl_pkg::cell_ctl_t   cell_ctl  [D];
  logic [D-1:0]          valid_v, lt_v, le_v, eq_v, holds_v;

  logic [D:0]                 bnd_l, bnd_s;
  logic [srtl_pkg::CNT_W-1:0] lb_idx, slot_idx;

  for (genvar k = 0; k < D; k++) begin : g_cell
    logic [W-1:0] nbr_base, nbr_len;
    if (k == 0) begin : g_first
      assign nbr_base = rbase;
      assign nbr_len  = rlen;
    end else begin : g_rest
      assign nbr_base = cell_base[k-1];
      assign nbr_len  = cell_len[k-1];
    end

    // cells at or above the slot move right; the slot cell takes the new region
    assign cell_ctl[k].load_new = ins_ok & bnd_s[k];
    assign cell_ctl[k].shift_in = ins_ok & ~le_v[k] & ~bnd_s[k];

    srtl_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl[k]),
      .new_base_i (rbase),
      .new_len_i  (rlen),
      .nbr_base_i (nbr_base),
      .nbr_len_i  (nbr_len),
      .addr_i     (addr),
      .base_o     (cell_base[k]),
      .len_o      (cell_len[k]),
      .flags_o    (cell_flags[k])
    );

    assign valid_v[k] = srtl_pkg::CNT_W'(k) < count_q;
    assign lt_v[k]    = valid_v[k] & cell_flags[k].lt_addr;
    assign le_v[k]    = valid_v[k] & cell_flags[k].le_ins;
    assign eq_v[k]    = valid_v[k] & cell_flags[k].eq_addr;
    assign holds_v[k] = cell_flags[k].holds;
  end

  // lower bound for find / lower bound, upper bound for the insert slot
  srtl_bound u_bound_lookup (
    .before_i (lt_v),
    .bnd_o    (bnd_l),
    .idx_o    (lb_idx)
  );

  srtl_bound u_bound_insert (
    .before_i (le_v),
    .bnd_o    (bnd_s),
    .idx_o    (slot_idx)
  );

  // find: per boundary position, hit and whether the hit is the entry below
  logic [D:0] hit_v, prev_v;
  logic       find_hit, use_prev;

  always_comb begin
    // first entry: containment only
    hit_v[0]  = (count_q != '0) & holds_v[0];
    prev_v[0] = 1'b0;
    for (int k = 1; k <= D; k++) begin
      if (k < D) begin
        hit_v[k]  = eq_v[k] | holds_v[k-1];
        prev_v[k] = ~eq_v[k] & holds_v[k-1];
      end else begin
        hit_v[k]  = holds_v[k-1];
        prev_v[k] = holds_v[k-1];
      end
    end
  end

  assign find_hit = |(bnd_l & hit_v);
  assign use_prev = |(bnd_l & prev_v);

  // result assembly
  logic       found_d, status_d;
  logic [srtl_pkg::POS_W-1:0] pos_d;

  always_comb begin
    count_d  = count_q;
    found_d  = 1'b0;
    status_d = 1'b0;
    pos_d    = '0;
    case (cmd)
      srtl_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      srtl_pkg::CMD_INSERT: begin
        if (full) begin
          status_d = 1'b1;
          pos_d    = srtl_pkg::POS_W'(count_q);
        end else begin
          count_d = count_q + srtl_pkg::CNT_W'(1);
          pos_d   = srtl_pkg::POS_W'(slot_idx);
        end
      end
      srtl_pkg::CMD_FIND: begin
        found_d = find_hit;
        pos_d   = srtl_pkg::POS_W'(lb_idx - srtl_pkg::CNT_W'(use_prev));
      end
      srtl_pkg::CMD_LBOUND: begin
        pos_d = srtl_pkg::POS_W'(lb_idx);
      end
      default: begin
        pos_d = '0;
      end
    endcase
  end

  // output register handshake
  logic        out_valid_q;
  logic [15:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {srtl_pkg::POS_W'(count_d), status_d, pos_d, found_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: hw/rtl/srtl_cell.sv
// One table cell: holds one region and compares it with the current transfer.
// Shifts in its left neighbor's region on an insert below it.
// Depends on srtl_pkg.
module srtl_cell (
  input  logic                         clk_i,
  input  srtl_pkg::cell_ctl_t          ctl_i,
  input  logic [srtl_pkg::ADDR_W-1:0]  new_base_i,
  input  logic [srtl_pkg::ADDR_W-1:0]  new_len_i,
  input  logic [srtl_pkg::ADDR_W-1:0]  nbr_base_i,
  input  logic [srtl_pkg::ADDR_W-1:0]  nbr_len_i,
  input  logic [srtl_pkg::ADDR_W-1:0]  addr_i,
  output logic [srtl_pkg::ADDR_W-1:0]  base_o,
  output logic [srtl_pkg::ADDR_W-1:0]  len_o,
  output srtl_pkg::cell_flags_t        flags_o
);

  logic [srtl_pkg::ADDR_W-1:0] base_q, base_d;
  logic [srtl_pkg::ADDR_W-1:0] len_q, len_d;
  logic [srtl_pkg::ADDR_W-1:0] end_addr;

  always_comb begin
    base_d = base_q;
    len_d  = len_q;
    if (ctl_i.load_new) begin
      base_d = new_base_i;
      len_d  = new_len_i;
    end else if (ctl_i.shift_in) begin
      base_d = nbr_base_i;
      len_d  = nbr_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    len_q  <= len_d;
  end

  // end wraps mod 2^32
  assign end_addr = base_q + len_q;

  always_comb begin
    flags_o.lt_addr = base_q < addr_i;
    flags_o.le_ins  = base_q <= new_base_i;
    flags_o.eq_addr = base_q == addr_i;
    flags_o.holds   = (addr_i >= base_q) && (addr_i < end_addr);
  end

  assign base_o = base_q;
  assign len_o  = len_q;

endmodule

FILE: hw/rtl/srtl_bound.sv
// Boundary encoder: finds where a sorted "before" flag row turns from 1 to 0.
// Gives the one-hot boundary and its index. Depends on srtl_pkg.
module srtl_bound (
  input  logic [srtl_pkg::TABLE_DEPTH-1:0] before_i,
  output logic [srtl_pkg::TABLE_DEPTH:0]   bnd_o,
  output logic [srtl_pkg::CNT_W-1:0]       idx_o
);

  logic [srtl_pkg::TABLE_DEPTH:0] ext;

  // virtual cell past the end is never before
  assign ext = {1'b0, before_i};

  always_comb begin
    bnd_o[0] = ~ext[0];
    for (int k = 1; k <= srtl_pkg::TABLE_DEPTH; k++) begin
      bnd_o[k] = ext[k-1] & ~ext[k];
    end
  end

  always_comb begin
    idx_o = '0;
    for (int k = 0; k <= srtl_pkg::TABLE_DEPTH; k++) begin
      if (bnd_o[k]) idx_o = idx_o | srtl_pkg::CNT_W'(k);
    end
  end

endmodule
